FILE: sv/chsi_pkg.sv
// ----------------------------------------------------------------------------
// chsi_pkg
// Shared types and constants of the cubic Hermite sample interpolator.
// ----------------------------------------------------------------------------
package chsi_pkg;

  // Field widths of the stream items
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 16;
  localparam int ADDR_BITS     = 12;
  localparam int FRAME_BITS    = 12;
  localparam int CHAN_BITS     = 3;
  localparam int IN_DATA_BITS  = 64;

  // Configuration register widths
  localparam int COUNT_BITS    = 13;
  localparam int CHCOUNT_BITS  = 4;

  // Frame index with room for k+2, and the interleaved index before clamping
  localparam int FRAME_EXT_BITS = FRAME_BITS + 1;
  localparam int IDX_BITS       = FRAME_EXT_BITS + CHCOUNT_BITS;

  // Datapath accumulator and the product of the shared unit
  localparam int ACC_BITS  = 24;
  localparam int PROD_BITS = ACC_BITS + FRACTION_BITS + 1;

  // Four taps per interpolation, three Horner steps
  localparam int NUM_TAPS  = 4;
  localparam int TAP_BITS  = 2;
  localparam int NUM_STEPS = 3;
  localparam int STEP_BITS = 2;

  // Saturation limits of a result sample
  localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [ACC_BITS-1:0] SAT_LO = -SAT_HI - ACC_BITS'(1);

  // Operation codes carried in tuser
  typedef enum logic [0:0] {
    OP_STORE  = 1'b0,
    OP_INTERP = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_SAMPLE_COUNT  = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } reg_index_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_MAC,
    ST_FINISH
  } state_t;

  // Control of the shared multiply unit
  typedef struct packed {
    logic clear;
    logic step;
  } mac_ctl_t;

endpackage

FILE: sv/chsi_ram.sv
// ----------------------------------------------------------------------------
// chsi_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module chsi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/chsi_mac.sv
// ----------------------------------------------------------------------------
// chsi_mac
// Shared Horner step unit: acc <= asr((acc + coef) * frac, FRACTION_BITS).
// ----------------------------------------------------------------------------
module chsi_mac
  import chsi_pkg::*;
(
  input  logic                       clk,
  input  mac_ctl_t                   ctl,
  input  logic signed [ACC_BITS-1:0] coef,
  input  logic [FRACTION_BITS-1:0]   frac,
  output logic signed [ACC_BITS-1:0] acc
);

  logic signed [ACC_BITS-1:0]  acc_r;
  logic signed [ACC_BITS-1:0]  acc_nxt;
  logic signed [ACC_BITS-1:0]  sum;
  logic signed [PROD_BITS-1:0] prod;

  // Add the coefficient, scale by the fraction, drop the fraction bits (floor)
  always_comb begin
    sum  = acc_r + coef;
    prod = PROD_BITS'(sum) * PROD_BITS'($signed({1'b0, frac}));
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.step) begin
      acc_nxt = ACC_BITS'(prod >>> FRACTION_BITS);
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

FILE: sv/cubic_hermite_sample_interpolator.sv
// ----------------------------------------------------------------------------
// cubic_hermite_sample_interpolator
// Interleaved sample memory with a 4-point cubic Hermite fractional read.
// ----------------------------------------------------------------------------
// Store item: written to memory in its accept cycle, next item in the cycle after.
// Interpolate item: four tap reads on the single RAM read port, a load state,
//   three Horner steps on one shared multiplier, a saturate state that waits for
//   the output to be free; no new item is taken until the result is registered.
// Reset: control state cleared, sample_count and channel_count set to 1;
//   memory contents are undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
module cubic_hermite_sample_interpolator
  import chsi_pkg::*;
#(
  parameter int MEM_DEPTH = 4096
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [0:0]              cfg_index,
  input  logic [COUNT_BITS-1:0]   cfg_data,
  // Input stream
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // [11:0] write_address, [27:12] write_sample, [39:28] position_whole,
  // [55:40] position_fraction, [58:56] channel, [63:59] zero
  input  logic [IN_DATA_BITS-1:0] in_tdata,
  // [0] operation
  input  logic [0:0]              in_tuser,
  // Result stream
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // [15:0] interpolated_sample
  output logic [SAMPLE_BITS-1:0]  out_tdata
);

  localparam int AW = $clog2(MEM_DEPTH);

  // Input fields
  logic [ADDR_BITS-1:0]     in_addr;
  logic [SAMPLE_BITS-1:0]   in_sample;
  logic [FRAME_BITS-1:0]    in_whole;
  logic [FRACTION_BITS-1:0] in_frac;
  logic [CHAN_BITS-1:0]     in_chan;
  op_t                      in_op;
  logic                     in_fire;

  assign in_addr   = in_tdata[ADDR_BITS-1:0];
  assign in_sample = in_tdata[27:12];
  assign in_whole  = in_tdata[39:28];
  assign in_frac   = in_tdata[55:40];
  assign in_chan   = in_tdata[58:56];
  assign in_op     = op_t'(in_tuser);
  assign in_fire   = in_tvalid && in_tready;

  // Registers
  state_t                   state_r, state_nxt;
  logic [TAP_BITS-1:0]      tap_r, tap_nxt;
  logic [STEP_BITS-1:0]     step_r, step_nxt;
  logic [COUNT_BITS-1:0]    sample_count_r;
  logic [CHCOUNT_BITS-1:0]  channel_count_r;
  logic [FRAME_BITS-1:0]    k_r;
  logic [FRACTION_BITS-1:0] t_r;
  logic [CHAN_BITS-1:0]     chan_r;
  logic [COUNT_BITS-1:0]    lim_m1_r, lim_m1_nxt;
  logic signed [SAMPLE_BITS-1:0] smp_r [NUM_TAPS];
  logic                     cap_en_r;
  logic [TAP_BITS-1:0]      cap_tap_r;
  logic                     out_valid_r;
  logic [SAMPLE_BITS-1:0]   out_data_r;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r  <= COUNT_BITS'(1);
      channel_count_r <= CHCOUNT_BITS'(1);
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_SAMPLE_COUNT:  sample_count_r  <= cfg_data;
        REG_CHANNEL_COUNT: channel_count_r <= cfg_data[CHCOUNT_BITS-1:0];
        default:           sample_count_r  <= sample_count_r;
      endcase
    end
  end

  // Clamp limit minus one: zero count acts as one, counts beyond depth cap
  always_comb begin
    if (sample_count_r == '0) begin
      lim_m1_nxt = '0;
    end else if (32'(sample_count_r) > 32'(MEM_DEPTH)) begin
      lim_m1_nxt = COUNT_BITS'(MEM_DEPTH - 1);
    end else begin
      lim_m1_nxt = sample_count_r - COUNT_BITS'(1);
    end
  end

  // Tap frame and clamped interleaved index
  logic [FRAME_EXT_BITS-1:0] frame;
  logic [IDX_BITS-1:0]       idx_raw;
  logic [COUNT_BITS-1:0]     idx_clamped;

  always_comb begin
    if (tap_r == '0) begin
      frame = (k_r == '0) ? '0 : FRAME_EXT_BITS'(k_r) - FRAME_EXT_BITS'(1);
    end else begin
      frame = FRAME_EXT_BITS'(k_r) + FRAME_EXT_BITS'(tap_r) - FRAME_EXT_BITS'(1);
    end
    idx_raw = IDX_BITS'(frame) * IDX_BITS'(channel_count_r) + IDX_BITS'(chan_r);
    if (idx_raw > IDX_BITS'(lim_m1_r)) begin
      idx_clamped = lim_m1_r;
    end else begin
      idx_clamped = idx_raw[COUNT_BITS-1:0];
    end
  end

  // Sample memory
  logic                   ram_wr_en;
  logic                   ram_rd_en;
  logic [SAMPLE_BITS-1:0] ram_rd_data;

  assign ram_wr_en = in_fire && (in_op == OP_STORE) && (32'(in_addr) < 32'(MEM_DEPTH));

  chsi_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (AW'(in_addr)),
    .wr_data (in_sample),
    .rd_en   (ram_rd_en),
    .rd_addr (AW'(idx_clamped)),
    .rd_data (ram_rd_data)
  );

  // Doubled Hermite coefficients from the four taps
  logic signed [ACC_BITS-1:0] sa, sb, sc, sd;
  logic signed [ACC_BITS-1:0] a2, b2, c2, coef;

  always_comb begin
    sa = ACC_BITS'(smp_r[0]);
    sb = ACC_BITS'(smp_r[1]);
    sc = ACC_BITS'(smp_r[2]);
    sd = ACC_BITS'(smp_r[3]);
    a2 = -sa + ACC_BITS'(3) * sb - ACC_BITS'(3) * sc + sd;
    b2 = ACC_BITS'(2) * sa - ACC_BITS'(5) * sb + ACC_BITS'(4) * sc - sd;
    c2 = sc - sa;
    unique case (step_r)
      2'd0:    coef = a2;
      2'd1:    coef = b2;
      default: coef = c2;
    endcase
  end

  // Shared Horner unit
  mac_ctl_t                   mac_ctl;
  logic signed [ACC_BITS-1:0] acc;

  chsi_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .coef (coef),
    .frac (t_r),
    .acc  (acc)
  );

  // Final half scale, add B, saturate
  logic signed [ACC_BITS-1:0] y_raw;
  logic [SAMPLE_BITS-1:0]     y_sat;
  logic                       out_free;

  always_comb begin
    y_raw = (acc >>> 1) + sb;
    if (y_raw > SAT_HI) begin
      y_sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (y_raw < SAT_LO) begin
      y_sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_raw[SAMPLE_BITS-1:0];
    end
  end

  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_op == OP_INTERP)) begin
          state_nxt = ST_FETCH;
          tap_nxt   = '0;
        end
      end
      ST_FETCH: begin
        tap_nxt = tap_r + TAP_BITS'(1);
        if (tap_r == TAP_BITS'(NUM_TAPS - 1)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_MAC;
        step_nxt  = '0;
      end
      ST_MAC: begin
        step_nxt = step_r + STEP_BITS'(1);
        if (step_r == STEP_BITS'(NUM_STEPS - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready     = 1'b0;
    ram_rd_en     = 1'b0;
    mac_ctl.clear = 1'b0;
    mac_ctl.step  = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_tready     = 1'b1;
      ST_FETCH:  ram_rd_en     = 1'b1;
      ST_LOAD:   mac_ctl.clear = 1'b1;
      ST_MAC:    mac_ctl.step  = 1'b1;
      ST_FINISH: ram_rd_en     = 1'b0;
      default:   in_tready     = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_r       <= '0;
      step_r      <= '0;
      cap_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tap_r    <= tap_nxt;
      step_r   <= step_nxt;
      cap_en_r <= (state_r == ST_FETCH);
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      k_r      <= in_whole;
      t_r      <= in_frac;
      chan_r   <= in_chan;
      lim_m1_r <= lim_m1_nxt;
    end
    cap_tap_r <= tap_r;
    if (cap_en_r) begin
      smp_r[cap_tap_r] <= $signed(ram_rd_data);
    end
    if (state_r == ST_FINISH && out_free) begin
      out_data_r <= y_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Assertions
  a_interp_starts_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op == OP_INTERP) |=> (state_r == ST_FETCH && tap_r == '0))
    else $error("interpolate item did not start the tap fetch");

  a_store_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op == OP_STORE) |=> (state_r == ST_IDLE && !$rose(out_tvalid)))
    else $error("store item left idle or produced a result");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> (idx_clamped <= lim_m1_r && 32'(idx_clamped) < 32'(MEM_DEPTH)))
    else $error("tap read address beyond clamp limit");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_FINISH))
    else $error("result raised outside the finish state");

endmodule
